// ===== rtl/wrp_pkg.sv =====
package wrp_pkg;

    localparam int unsigned MIN_FILE      = 44;
    localparam int unsigned WALK_START    = 12;
    localparam int unsigned FMT_MIN       = 16;
    localparam logic [3:0]  FMT_BODY_LEN  = 4'd8;
    localparam logic [31:0] ID_FMT        = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA       = 32'h6174_6164;

    localparam logic [7:0] RIFF_SIG [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0] WAVE_SIG [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

    typedef enum logic [2:0] {
        PH_SIG = 3'b001,
        PH_HDR = 3'b010,
        PH_FMT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [31:0] byte_pos;
        logic [33:0] next_start;
        logic [63:0] shift;
        t_phase      phase;
        logic        stopped;
        logic        sig_ok;
        logic        fmt_found;
        logic        data_found;
        logic [31:0] rate;
        logic [15:0] chans;
        logic [31:0] doff;
        logic [31:0] dsize;
        logic [3:0]  body_left;
    } t_parse;

    typedef struct packed {
        logic        header_ok;
        logic [31:0] sample_rate;
        logic [15:0] channels;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_result;

    localparam t_parse PARSE_RESET = '{
        byte_pos:   32'd0,
        next_start: 34'(WALK_START),
        shift:      64'd0,
        phase:      PH_SIG,
        stopped:    1'b0,
        sig_ok:     1'b1,
        fmt_found:  1'b0,
        data_found: 1'b0,
        rate:       32'd0,
        chans:      16'd0,
        doff:       32'd0,
        dsize:      32'd0,
        body_left:  4'd0
    };

endpackage

// ===== rtl/wrp_walk.sv =====
module wrp_walk (
    input  wrp_pkg::t_parse  i_state,
    input  logic [7:0]       i_byte,
    input  logic [31:0]      i_file_size,
    output wrp_pkg::t_parse  o_state,
    output wrp_pkg::t_result o_result
);
    import wrp_pkg::*;

    t_parse      n;
    logic [31:0] p;
    logic [33:0] p34;
    logic [33:0] start;
    logic [33:0] rel;
    logic [34:0] start_p8;
    logic [34:0] chunk_end;
    logic [34:0] padded_end;
    logic [63:0] shifted;
    logic [31:0] size;
    logic [31:0] id;
    logic        walk_ok;
    logic        valid_file;

    assign p          = i_state.byte_pos;
    assign p34        = {2'b00, p};
    assign start      = i_state.next_start;
    assign rel        = p34 - start;
    assign start_p8   = {1'b0, start} + 35'd8;
    assign shifted    = {i_byte, i_state.shift[63:8]};
    assign size       = shifted[63:32];
    assign id         = shifted[31:0];
    assign chunk_end  = start_p8 + {3'b000, size};
    assign padded_end = chunk_end + {34'd0, size[0]};
    assign walk_ok    = i_state.sig_ok && (i_file_size >= 32'(MIN_FILE)) && !i_state.stopped;

    always_comb begin
        n = i_state;
        if (p != '1) begin
            n.byte_pos = p + 32'd1;
        end
        if (p < i_file_size) begin
            if (p < 32'd4) begin
                if (i_byte != RIFF_SIG[p[1:0]]) n.sig_ok = 1'b0;
            end else if (p < 32'd8) begin
                n.sig_ok = i_state.sig_ok;
            end else if (p < 32'(WALK_START)) begin
                if (i_byte != WAVE_SIG[p[1:0]]) n.sig_ok = 1'b0;
            end else if (walk_ok) begin
                unique case (i_state.phase)
                    PH_FMT: begin
                        n.shift = shifted;
                        if (i_state.body_left != 4'd0) begin
                            n.body_left = i_state.body_left - 4'd1;
                        end
                        if (n.body_left == 4'd0) begin
                            n.chans     = shifted[31:16];
                            n.rate      = shifted[63:32];
                            n.fmt_found = 1'b1;
                            n.phase     = PH_HDR;
                        end
                    end
                    default: begin
                        n.phase = PH_HDR;
                        if (p34 >= start) begin
                            if (rel > 34'd7 ||
                                (rel == 34'd0 && !(start_p8 < {3'b000, i_file_size}))) begin
                                n.stopped = 1'b1;
                            end else begin
                                n.shift = shifted;
                                if (rel == 34'd7) begin
                                    // chunk header complete: id in low word, size in high word
                                    if (chunk_end > {3'b000, i_file_size}) begin
                                        n.stopped = 1'b1;
                                    end else begin
                                        if (id == ID_FMT && size >= 32'(FMT_MIN)) begin
                                            n.phase     = PH_FMT;
                                            n.body_left = FMT_BODY_LEN;
                                            n.shift     = 64'd0;
                                        end else if (id == ID_DATA) begin
                                            n.doff       = start_p8[31:0];
                                            n.dsize      = size;
                                            n.data_found = 1'b1;
                                        end
                                        n.next_start = padded_end[33:0];
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign valid_file = n.sig_ok && (i_file_size >= 32'(MIN_FILE));
    assign o_state    = n;

    always_comb begin
        o_result.header_ok   = valid_file && n.fmt_found && n.data_found;
        o_result.sample_rate = (valid_file && n.fmt_found)  ? n.rate  : 32'd0;
        o_result.channels    = (valid_file && n.fmt_found)  ? n.chans : 16'd0;
        o_result.data_offset = (valid_file && n.data_found) ? n.doff  : 32'd0;
        o_result.data_size   = (valid_file && n.data_found) ? n.dsize : 32'd0;
    end

endmodule

// ===== rtl/wav_riff_header_parser_core.sv =====
// The result register takes the summary when a last byte leaves the input register and that register is free.
// Throughput: one byte per cycle unless a last byte waits on a busy result register; the single
// walk stage between the input register and the result register updates the parse state for one byte each cycle.
// A result waiting on stall holds the walk only when the next byte is itself a last byte.
// Reset (synchronous, active low) clears all parse state, file_size and both valid flags.
module wav_riff_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_header_ok,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_channels,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_size
);
    import wrp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_file_size;
    t_parse      r_state;
    t_parse      n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_parse      walk_state;
    t_result     walk_result;
    logic        out_free;
    logic        fire;
    logic        in_ready;

    wrp_walk u_walk (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .i_file_size (r_file_size),
        .o_state     (walk_state),
        .o_result    (walk_result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && (!r_in_last || out_free);
    assign in_ready = !r_in_valid || fire;
    assign o_stall  = !in_ready;

    // a last byte starts a new file from offset zero
    assign n_state = r_in_last ? PARSE_RESET : walk_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_file_size <= 32'd0;
            r_state     <= PARSE_RESET;
        end else begin
            if (i_cfg_we) r_file_size <= i_cfg_data;
            if (i_valid && in_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) r_state <= n_state;
            if (fire && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (fire && r_in_last) r_out <= walk_result;
    end

    assign o_valid       = r_out_valid;
    assign o_header_ok   = r_out.header_ok;
    assign o_sample_rate = r_out.sample_rate;
    assign o_channels    = r_out.channels;
    assign o_data_offset = r_out.data_offset;
    assign o_data_size   = r_out.data_size;

endmodule

// ===== rtl/wrp_checker.sv =====
module wrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_header_ok,
    input logic [31:0] o_sample_rate,
    input logic [15:0] o_channels,
    input logic [31:0] o_data_offset,
    input logic [31:0] o_data_size
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_header_ok) && $stable(o_sample_rate) &&
            $stable(o_channels) && $stable(o_data_offset) && $stable(o_data_size))
        else $error("result dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall set after reset");

    // data payload always follows the signatures and one chunk header
    a_offset_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_header_ok |-> o_data_offset >= 32'd20)
        else $error("data offset below first possible payload");

    // with the output register empty the input never waits
    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with free output");

endmodule

bind wav_riff_header_parser_core wrp_checker u_wrp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import wrp_pkg::*;

    // Signature words as they read little endian from the byte stream
    localparam logic [31:0] RIFF_WORD     = 32'h4646_4952;
    localparam logic [31:0] WAVE_WORD     = 32'h4556_4157;
    localparam logic [31:0] LIST_ID       = 32'h5453_494C;
    localparam int unsigned ITEM_TARGET   = 1200;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned WATCHDOG_MAX  = 2000;
    localparam int unsigned DRAIN_CYCLES  = 6;

    class wav_header_scoreboard;
        logic [31:0] file_size;
        logic [31:0] pos;
        logic [33:0] chunk_start;
        logic [63:0] shreg;
        t_phase      phase;
        logic        walk_done;
        logic        sig_good;
        logic        fmt_seen;
        logic        data_seen;
        logic [31:0] rate;
        logic [15:0] chans;
        logic [31:0] doff;
        logic [31:0] dsize;
        logic [3:0]  fmt_left;
        t_result     header_q[$];
        int unsigned mismatches;
        int unsigned files_done;
        int unsigned files_good;

        function new();
            file_size  = '0;
            mismatches = 0;
            files_done = 0;
            files_good = 0;
            restart();
        endfunction

        function void restart();
            pos         = '0;
            chunk_start = 34'(WALK_START);
            shreg       = '0;
            phase       = PH_SIG;
            walk_done   = 1'b0;
            sig_good    = 1'b1;
            fmt_seen    = 1'b0;
            data_seen   = 1'b0;
            rate        = '0;
            chans       = '0;
            doff        = '0;
            dsize       = '0;
            fmt_left    = '0;
        endfunction

        // Advance the header walk by one accepted byte; a last byte queues the summary
        function void note_byte(input logic [7:0] b, input logic last);
            logic [63:0] start;
            logic [63:0] rel;
            logic [63:0] csz;
            logic [63:0] stop;
            logic [31:0] id;
            logic        valid_file;
            t_result     r;
            if (pos < file_size) begin
                if (pos < 4) begin
                    if (b != RIFF_WORD[8*pos[1:0] +: 8]) sig_good = 1'b0;
                end else if (pos >= 8 && pos < WALK_START) begin
                    if (b != WAVE_WORD[8*pos[1:0] +: 8]) sig_good = 1'b0;
                end else if (pos >= WALK_START && sig_good && file_size >= MIN_FILE
                             && !walk_done) begin
                    if (phase == PH_FMT) begin
                        shreg = {b, shreg[63:8]};
                        if (fmt_left > 0) fmt_left--;
                        if (fmt_left == 0) begin
                            chans    = shreg[31:16];
                            rate     = shreg[63:32];
                            fmt_seen = 1'b1;
                            phase    = PH_HDR;
                        end
                    end else begin
                        phase = PH_HDR;
                        start = 64'(chunk_start);
                        if (64'(pos) >= start) begin
                            rel = 64'(pos) - start;
                            // header needs more than 8 bytes left after the chunk start
                            if (rel > 7 || (rel == 0 && !(start + 8 < 64'(file_size)))) begin
                                walk_done = 1'b1;
                            end else begin
                                shreg = {b, shreg[63:8]};
                                if (rel == 7) begin
                                    id   = shreg[31:0];
                                    csz  = 64'(shreg[63:32]);
                                    stop = start + 8 + csz;
                                    if (stop > 64'(file_size)) begin
                                        walk_done = 1'b1;
                                    end else begin
                                        if (id == ID_FMT && csz >= FMT_MIN) begin
                                            phase    = PH_FMT;
                                            fmt_left = FMT_BODY_LEN;
                                            shreg    = '0;
                                        end else if (id == ID_DATA) begin
                                            doff      = 32'(start + 8);
                                            dsize     = 32'(csz);
                                            data_seen = 1'b1;
                                        end
                                        chunk_start = 34'(stop + csz[0]);
                                    end
                                end
                            end
                        end
                    end
                end
            end
            if (pos != '1) pos++;
            if (last) begin
                valid_file    = sig_good && file_size >= MIN_FILE;
                r.header_ok   = valid_file && fmt_seen && data_seen;
                r.sample_rate = (valid_file && fmt_seen) ? rate : '0;
                r.channels    = (valid_file && fmt_seen) ? chans : '0;
                r.data_offset = (valid_file && data_seen) ? doff : '0;
                r.data_size   = (valid_file && data_seen) ? dsize : '0;
                header_q.push_back(r);
                restart();
            end
        endfunction

        function void check_result(input logic hdr, input logic [31:0] srate,
                                   input logic [15:0] ch, input logic [31:0] off,
                                   input logic [31:0] sz);
            t_result want;
            if (header_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no file pending: ok=%0b rate=%0h ch=%0h",
                             hdr, srate, ch);
                return;
            end
            want = header_q.pop_front();
            files_done++;
            if (want.header_ok) files_good++;
            if (want.header_ok !== hdr || want.sample_rate !== srate ||
                want.channels !== ch || want.data_offset !== off ||
                want.data_size !== sz) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: file %0d exp ok=%0b rate=%0h ch=%0h off=%0h size=%0h",
                             files_done, want.header_ok, want.sample_rate, want.channels,
                             want.data_offset, want.data_size);
                    $display("       file %0d got ok=%0b rate=%0h ch=%0h off=%0h size=%0h",
                             files_done, hdr, srate, ch, off, sz);
                end
            end
        endfunction

        function int unsigned pending();
            return header_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic        o_header_ok;
    logic [31:0] o_sample_rate;
    logic [15:0] o_channels;
    logic [31:0] o_data_offset;
    logic [31:0] o_data_size;

    wav_header_scoreboard sb = new();
    logic [7:0]  file_bytes[$];
    int unsigned bytes_sent   = 0;
    int unsigned bytes_parsed = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned idle_cycles  = 0;
    bit          hold_req     = 1'b0;

    wav_riff_header_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_header_ok   (o_header_ok),
        .o_sample_rate (o_sample_rate),
        .o_channels    (o_channels),
        .o_data_offset (o_data_offset),
        .o_data_size   (o_data_size)
    );

    always #2 i_clk = ~i_clk;

    task automatic send_byte(input logic [7:0] b, input logic last);
        // no gaps for a stretch in the middle of the run
        if (!(bytes_sent >= 600 && bytes_sent < 850) && $urandom_range(99) < 10) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_file_size(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.file_size = v;
    endtask

    function automatic void push_le32(input logic [31:0] w);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[31:24]);
    endfunction

    // Mostly well-formed RIFF/WAVE files sized to the register, with random chunk
    // content, plus noise, broken signatures, early ends and trailing bytes.
    task automatic build_file(input logic [31:0] fsize);
        int unsigned target;
        int unsigned room;
        int unsigned csize;
        int unsigned k;
        int unsigned n;
        int unsigned nchunks;
        int unsigned r;
        logic [31:0] cid;
        file_bytes.delete();
        target = (fsize == 0 || fsize > 400) ? 44 + $urandom_range(120) : fsize;
        if ($urandom_range(99) < 5) begin
            repeat (1 + $urandom_range(79)) file_bytes.push_back(8'($urandom));
            return;
        end
        push_le32(RIFF_WORD);
        push_le32($urandom);
        push_le32(WAVE_WORD);
        nchunks = 0;
        while (file_bytes.size() + 8 <= target && nchunks < 6) begin
            room = target - file_bytes.size() - 8;
            k = $urandom_range(9);
            if (nchunks == 0 && $urandom_range(3) != 0) k = 0;
            if (k < 3) begin
                cid = ID_FMT;
                r = $urandom_range(9);
                csize = (r < 6) ? 16 : (r < 8) ? 16 + $urandom_range(9) : $urandom_range(15);
            end else if (k < 7) begin
                cid = ID_DATA;
                r = $urandom_range(19);
                if (r == 0) csize = $urandom;
                else if (r < 3) csize = room + 1 + $urandom_range(8);
                else csize = $urandom_range(room);
            end else begin
                cid = (k == 9) ? 32'($urandom) : LIST_ID;
                csize = $urandom_range(13);
            end
            push_le32(cid);
            push_le32(csize);
            n = (csize > target) ? target : csize;
            repeat (n) file_bytes.push_back(8'($urandom));
            if (csize[0]) file_bytes.push_back(8'($urandom));
            nchunks++;
        end
        while (file_bytes.size() > target) void'(file_bytes.pop_back());
        while (file_bytes.size() < target) file_bytes.push_back(8'($urandom));
        r = $urandom_range(99);
        if (r < 6) begin
            k = $urandom_range(7);
            if (k >= 4) k += 4;
            if (k < file_bytes.size()) file_bytes[k] ^= 8'(1 + $urandom_range(254));
        end else if (r < 14) begin
            n = 1 + $urandom_range(file_bytes.size() - 1);
            while (file_bytes.size() > n) void'(file_bytes.pop_back());
        end else if (r < 22) begin
            repeat (1 + $urandom_range(9)) file_bytes.push_back(8'($urandom));
        end
    endtask

    // Receiver: random stalls, a quiet window, and one long hold-off on request
    initial begin : rx_stall
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (cycle_cnt > 2000 && cycle_cnt < 3500) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 10);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_header_ok, o_sample_rate, o_channels, o_data_offset,
                            o_data_size);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_MAX);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned r;
        int unsigned i;
        int unsigned nfiles;
        int unsigned settings;
        logic [31:0] fs;
        bit          hold_used;
        hold_used = 1'b0;
        settings  = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty file: anything sent is past the end
        set_file_size('0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h52, 1'b1);
        drain();
        // One byte short of a minimal header, signatures correct
        set_file_size(32'd43);
        for (i = 0; i < 4; i++) send_byte(RIFF_WORD[8*i +: 8], 1'b0);
        for (i = 0; i < 4; i++) send_byte(8'hFF, 1'b0);
        for (i = 0; i < 4; i++) send_byte(WAVE_WORD[8*i +: 8], 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();
        // Bad second signature byte, file ends early
        set_file_size(32'd44);
        send_byte(8'h52, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
        set_file_size('1);
        send_byte(8'h52, 1'b0);
        send_byte(8'h49, 1'b0);
        send_byte(8'h46, 1'b1);
        settings = 4;

        while (bytes_parsed < ITEM_TARGET) begin
            drain();
            r = $urandom_range(99);
            if (!hold_used && bytes_parsed > 300) begin
                // short files so the result stage backs up into the input
                hold_used = 1'b1;
                hold_req  = 1'b1;
                fs = 32'd44;
                nfiles = 6;
            end else begin
                if (r < 5) fs = '0;
                else if (r < 10) fs = '1;
                else if (r < 15) fs = 32'd43;
                else if (r < 22) fs = 32'd44;
                else if (r < 27) fs = $urandom_range(42, 1);
                else if (r < 32) fs = $urandom_range(400, 161);
                else fs = $urandom_range(160, 45);
                nfiles = 2 + $urandom_range(3);
            end
            set_file_size(fs);
            settings++;
            repeat (nfiles) begin
                build_file(fs);
                for (i = 0; i < file_bytes.size(); i++) begin
                    send_byte(file_bytes[i], i == file_bytes.size() - 1);
                    if (i < fs) bytes_parsed++;
                end
            end
        end
        drain();

        $display("Run covered %0d files (%0d with complete headers), %0d bytes, %0d sizes.",
                 sb.files_done, sb.files_good, bytes_sent, settings);
        $display("Mismatch count: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
